/* hw/rtl/hkm_pkg.sv */
// hkm_pkg: shared types, field widths and codes for the hash key map core.
// No dependencies. Used by hkm_front, hkm_back and the top level.
`default_nettype none

package hkm_pkg;

    localparam int KEY_W   = 32;
    localparam int OFS_W   = 17;
    localparam int LIM_W   = 13;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 2;

    localparam int DEF_MAX_ENTRIES = 4096;
    localparam int DEF_SLOT_COUNT  = 8192;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 13'd4096;

    // stream payload widths (bytes rounded)
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 64;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_IGNORE = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_SLOT,
        BK_KEY,
        BK_DONE
    } t_bk_state;

    typedef struct packed {
        t_req             req;
        logic [KEY_W-1:0] key;
        logic [OFS_W-1:0] art;
        logic [OFS_W-1:0] alb;
        logic [OFS_W-1:0] tit;
    } t_item;

    typedef struct packed {
        t_status          status;
        logic [OFS_W-1:0] art;
        logic [OFS_W-1:0] alb;
        logic [OFS_W-1:0] tit;
        logic [LIM_W-1:0] held;
    } t_result;

endpackage

`default_nettype wire

/* hw/rtl/hash_key_linear_probe_map_core.sv */
// Hash map keyed by a 32-bit path hash: open addressing with linear probing
// over a SLOT_COUNT slot table (power of two) that points into an append-only
// entry store of MAX_ENTRIES records. Insert (req 0) appends and takes the
// first empty slot from key & (SLOT_COUNT-1); lookup (req 1) returns the
// first entry with an equal hash; clear (req 2) empties the map. Requests
// enter a two-deep queue; the engine works on one at a time because all
// probes go through the single read port of the slot table with registered
// read data. Per request, a lookup reads each probed slot and then the
// entry key that it points to; an insert reads only slots until it finds an
// empty one; refused or ignored requests and lookups on an empty map go
// straight to the result; clear sweeps the whole slot table.
// After reset the slot table is swept to empty; the request input is not
// ready during that sweep nor during a clear sweep.
// Configuration writes (entry_limit) are always taken.
// Depends on hkm_pkg, hkm_front, hkm_back.
`default_nettype none

module hash_key_linear_probe_map_core #(
    parameter int MAX_ENTRIES = hkm_pkg::DEF_MAX_ENTRIES,
    parameter int SLOT_COUNT  = hkm_pkg::DEF_SLOT_COUNT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [hkm_pkg::LIM_W-1:0]      i_cfg_data,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // key_hash[31:0], artist_offset[48:32], album_offset[65:49], title_offset[82:66]
    input  wire logic [hkm_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // req_type[1:0]
    input  wire logic [hkm_pkg::REQ_W-1:0]      i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // found_artist[16:0], found_album[33:17], found_title[50:34], entries_held[63:51]
    output logic [hkm_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    // status[1:0]
    output logic [hkm_pkg::STAT_W-1:0]          o_m_axis_tuser
);
    import hkm_pkg::*;

    logic    q_valid;
    t_item   q_item;
    logic    q_pop;
    logic    clear_busy;
    t_result res;

    assign o_cfg_ready = 1'b1;

    hkm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_clear_busy    (clear_busy),
        .o_q_valid       (q_valid),
        .o_q_item        (q_item),
        .i_q_pop         (q_pop)
    );

    hkm_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .SLOT_COUNT  (SLOT_COUNT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .o_q_pop      (q_pop),
        .o_clear_busy (clear_busy),
        .o_res_valid  (o_m_axis_tvalid),
        .i_res_ready  (i_m_axis_tready),
        .o_res        (res)
    );

    assign o_m_axis_tdata = {res.held, res.tit, res.alb, res.art};
    assign o_m_axis_tuser = res.status;

endmodule

`default_nettype wire

/* hw/rtl/hkm_front.sv */
// hkm_front: accepts request transfers, decodes them and holds them in a
// two-entry queue for the back end. Depends on hkm_pkg.
`default_nettype none

module hkm_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // key_hash[31:0], artist_offset[48:32], album_offset[65:49], title_offset[82:66]
    input  wire logic [hkm_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // req_type[1:0]
    input  wire logic [hkm_pkg::REQ_W-1:0]      i_s_axis_tuser,
    input  wire logic                           i_clear_busy,
    output logic                                o_q_valid,
    output hkm_pkg::t_item                      o_q_item,
    input  wire logic                           i_q_pop
);
    import hkm_pkg::*;

    t_item       r_q [2];
    logic        r_wr;
    logic        r_rd;
    logic [1:0]  r_fill;
    logic        push;
    t_item       in_item;

    always_comb begin
        in_item.req = t_req'(i_s_axis_tuser);
        in_item.key = i_s_axis_tdata[KEY_W-1:0];
        in_item.art = i_s_axis_tdata[KEY_W +: OFS_W];
        in_item.alb = i_s_axis_tdata[KEY_W + OFS_W +: OFS_W];
        in_item.tit = i_s_axis_tdata[KEY_W + 2*OFS_W +: OFS_W];
    end

    // no intake while the slot table is being swept
    assign o_s_axis_tready = (r_fill != 2'd2) && !i_clear_busy;
    assign push            = i_s_axis_tvalid && o_s_axis_tready;
    assign o_q_valid       = (r_fill != 2'd0);
    assign o_q_item        = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= 1'b0;
            r_rd   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_q_pop) begin
                r_rd <= ~r_rd;
            end
            case ({push, i_q_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/hkm_back.sv */
// hkm_back: executes queued requests against the slot table and entry store,
// sweeps the slot table on reset and clear, and holds the result register.
// Depends on hkm_pkg.
`default_nettype none

module hkm_back #(
    parameter int MAX_ENTRIES = hkm_pkg::DEF_MAX_ENTRIES,
    parameter int SLOT_COUNT  = hkm_pkg::DEF_SLOT_COUNT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    input  wire logic [hkm_pkg::LIM_W-1:0]   i_cfg_data,
    input  wire logic                        i_q_valid,
    input  hkm_pkg::t_item                   i_q_item,
    output logic                             o_q_pop,
    output logic                             o_clear_busy,
    output logic                             o_res_valid,
    input  wire logic                        i_res_ready,
    output hkm_pkg::t_result                 o_res
);
    import hkm_pkg::*;

    localparam int SW   = $clog2(SLOT_COUNT);
    localparam int EW   = $clog2(MAX_ENTRIES);
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int CMPW = (CW > LIM_W) ? CW : LIM_W;
    localparam int OW   = 3 * OFS_W;

    // memories
    logic [CW-1:0]    r_slot_mem [SLOT_COUNT];
    logic [KEY_W-1:0] r_key_mem  [MAX_ENTRIES];
    logic [OW-1:0]    r_ofs_mem  [MAX_ENTRIES];
    logic [CW-1:0]    r_slot_data;
    logic [KEY_W-1:0] r_key_data;
    logic [OW-1:0]    r_ofs_data;

    t_bk_state        r_state, n_state;
    t_item            r_item, n_item;
    logic [SW-1:0]    r_slot, n_slot;
    logic [SW-1:0]    r_probe, n_probe;
    logic [SW-1:0]    r_clr_addr, n_clr_addr;
    logic             r_clr_reply, n_clr_reply;
    logic [CW-1:0]    r_count, n_count;
    logic [LIM_W-1:0] r_limit;
    t_result          r_res, n_res;
    logic             r_out_valid, n_out_valid;
    t_result          r_out, n_out;

    logic             slot_we;
    logic [SW-1:0]    slot_wa, slot_ra, slot_nxt;
    logic [CW-1:0]    slot_wd, slot_dec;
    logic             ent_we;
    logic [EW-1:0]    ent_ra;

    logic [CMPW-1:0]  count_ext, lim_ext, eff_lim;
    logic             is_full, slot_empty, probe_last, clr_last, key_hit, out_free;

    assign slot_nxt   = r_slot + 1'b1;
    assign slot_dec   = r_slot_data - 1'b1;
    assign ent_ra     = slot_dec[EW-1:0];
    assign count_ext  = CMPW'(r_count);
    assign lim_ext    = CMPW'(r_limit);
    assign eff_lim    = (lim_ext > CMPW'(MAX_ENTRIES)) ? CMPW'(MAX_ENTRIES) : lim_ext;
    assign is_full    = count_ext >= eff_lim;
    assign slot_empty = (r_slot_data == '0);
    assign probe_last = (r_probe == SW'(SLOT_COUNT - 1));
    assign clr_last   = (r_clr_addr == SW'(SLOT_COUNT - 1));
    assign key_hit    = (r_key_data == r_item.key);
    assign out_free   = !r_out_valid || i_res_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_CLEAR: begin
                if (clr_last) begin
                    n_state = r_clr_reply ? BK_DONE : BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_item.req)
                        REQ_INSERT: n_state = is_full ? BK_DONE : BK_SLOT;
                        REQ_LOOKUP: n_state = (r_count == '0) ? BK_DONE : BK_SLOT;
                        REQ_CLEAR:  n_state = BK_CLEAR;
                        REQ_IGNORE: n_state = BK_DONE;
                        default:    n_state = BK_DONE;
                    endcase
                end
            end
            BK_SLOT: begin
                if (slot_empty) begin
                    n_state = BK_DONE;
                end else if (r_item.req == REQ_LOOKUP) begin
                    n_state = BK_KEY;
                end else if (probe_last) begin
                    n_state = BK_DONE;
                end
            end
            BK_KEY: begin
                if (key_hit || probe_last) begin
                    n_state = BK_DONE;
                end else begin
                    n_state = BK_SLOT;
                end
            end
            BK_DONE: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_item      = r_item;
        n_slot      = r_slot;
        n_probe     = r_probe;
        n_clr_addr  = r_clr_addr;
        n_clr_reply = r_clr_reply;
        n_count     = r_count;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_res_ready;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        slot_we     = 1'b0;
        slot_wa     = r_slot;
        slot_wd     = '0;
        slot_ra     = r_slot;
        ent_we      = 1'b0;

        unique case (r_state)
            BK_CLEAR: begin
                slot_we    = 1'b1;
                slot_wa    = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                n_count    = '0;
                if (clr_last) begin
                    n_res = '{status: STAT_OK, art: '0, alb: '0, tit: '0, held: '0};
                end
            end
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_item  = i_q_item;
                    n_slot  = i_q_item.key[SW-1:0];
                    slot_ra = i_q_item.key[SW-1:0];
                    n_probe = '0;
                    n_res   = '{status: STAT_OK, art: '0, alb: '0, tit: '0, held: '0};
                    case (i_q_item.req)
                        REQ_INSERT: begin
                            if (is_full) begin
                                n_res.status = STAT_FULL;
                            end
                        end
                        REQ_LOOKUP: begin
                            if (r_count == '0) begin
                                n_res.status = STAT_MISS;
                            end
                        end
                        REQ_CLEAR: begin
                            n_clr_addr  = '0;
                            n_clr_reply = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            BK_SLOT: begin
                if (r_item.req == REQ_LOOKUP) begin
                    if (slot_empty) begin
                        n_res.status = STAT_MISS;
                    end
                end else if (slot_empty) begin
                    // free slot: append entry, point the slot at it
                    slot_we = 1'b1;
                    slot_wd = r_count + 1'b1;
                    ent_we  = 1'b1;
                    n_count = r_count + 1'b1;
                end else if (probe_last) begin
                    n_res.status = STAT_FULL;
                end else begin
                    n_slot  = slot_nxt;
                    slot_ra = slot_nxt;
                    n_probe = r_probe + 1'b1;
                end
            end
            BK_KEY: begin
                if (key_hit) begin
                    n_res.art = r_ofs_data[OFS_W-1:0];
                    n_res.alb = r_ofs_data[OFS_W +: OFS_W];
                    n_res.tit = r_ofs_data[2*OFS_W +: OFS_W];
                end else if (probe_last) begin
                    n_res.status = STAT_MISS;
                end else begin
                    n_slot  = slot_nxt;
                    slot_ra = slot_nxt;
                    n_probe = r_probe + 1'b1;
                end
            end
            BK_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_out.held  = count_ext[LIM_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign o_clear_busy = (r_state == BK_CLEAR);
    assign o_res_valid  = r_out_valid;
    assign o_res        = r_out;

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot_mem[slot_wa] <= slot_wd;
        end
        r_slot_data <= r_slot_mem[slot_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) begin
            r_key_mem[r_count[EW-1:0]] <= r_item.key;
            r_ofs_mem[r_count[EW-1:0]] <= {r_item.tit, r_item.alb, r_item.art};
        end
        r_key_data <= r_key_mem[ent_ra];
        r_ofs_data <= r_ofs_mem[ent_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
            r_count     <= '0;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_clr_reply <= n_clr_reply;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_slot  <= n_slot;
        r_probe <= n_probe;
        r_res   <= n_res;
        r_out   <= n_out;
    end

endmodule

`default_nettype wire

/* tb/sv/tb_hash_key_linear_probe_map_core.sv */
// Self-checking testbench for hash_key_linear_probe_map_core: insert, lookup and clear traffic
// is checked against a behavioral copy of the linear probing map kept in a scoreboard class.
// Depends on hkm_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_hash_key_linear_probe_map_core;
    import hkm_pkg::*;

    localparam int MAP_ENTRIES = DEF_MAX_ENTRIES;
    localparam int SLOT_TOTAL  = DEF_SLOT_COUNT;
    localparam int QUIET_LIMIT = 30000;   // > reset sweep, clear sweep, long hold-off
    localparam int HOLD_CYCLES = 300;
    localparam logic [12:0] CLUSTER_BASE = 13'h1FF8;   // chains wrap past the last slot

    class probe_map_scoreboard;
        logic [KEY_W-1:0]   key_store [MAP_ENTRIES];
        logic [3*OFS_W-1:0] ofs_store [MAP_ENTRIES];
        int unsigned        slot_table [SLOT_TOTAL];
        int unsigned        entry_count;
        int unsigned        entry_limit;
        t_result            pending_replies [$];
        int mismatch_count, reply_count, stored_count, refused_count;
        int hit_count, miss_count, clear_count, ignored_count;

        function new();
            foreach (slot_table[i]) slot_table[i] = 0;
            entry_count = 0;
            entry_limit = LIMIT_RESET;
        endfunction

        function void set_limit(logic [LIM_W-1:0] v);
            entry_limit = v;
        endfunction

        function t_result predict_map_reply(t_item it);
            t_result     r;
            int unsigned cap, s, e;
            bit          placed;
            r = '0;
            case (it.req)
                REQ_INSERT: begin
                    cap = (entry_limit > MAP_ENTRIES) ? MAP_ENTRIES : entry_limit;
                    placed = 1'b0;
                    if (entry_count < cap) begin
                        s = it.key & (SLOT_TOTAL - 1);
                        for (int n = 0; n < SLOT_TOTAL; n++) begin
                            if (slot_table[s] == 0) begin
                                placed = 1'b1;
                                break;
                            end
                            s = (s + 1) & (SLOT_TOTAL - 1);
                        end
                    end
                    if (placed) begin
                        key_store[entry_count] = it.key;
                        ofs_store[entry_count] = {it.tit, it.alb, it.art};
                        slot_table[s] = entry_count + 1;
                        entry_count++;
                        stored_count++;
                    end else begin
                        r.status = STAT_FULL;
                        refused_count++;
                    end
                end
                REQ_LOOKUP: begin
                    r.status = STAT_MISS;
                    if (entry_count != 0) begin
                        s = it.key & (SLOT_TOTAL - 1);
                        for (int n = 0; n < SLOT_TOTAL; n++) begin
                            if (slot_table[s] == 0) break;
                            e = slot_table[s] - 1;
                            if (key_store[e] == it.key) begin
                                r.status = STAT_OK;
                                r.art = ofs_store[e][OFS_W-1:0];
                                r.alb = ofs_store[e][2*OFS_W-1:OFS_W];
                                r.tit = ofs_store[e][3*OFS_W-1:2*OFS_W];
                                break;
                            end
                            s = (s + 1) & (SLOT_TOTAL - 1);
                        end
                    end
                    if (r.status == STAT_OK) hit_count++;
                    else miss_count++;
                end
                REQ_CLEAR: begin
                    foreach (slot_table[i]) slot_table[i] = 0;
                    entry_count = 0;
                    clear_count++;
                end
                default: ignored_count++;
            endcase
            r.held = LIM_W'(entry_count);
            return r;
        endfunction

        function void note_request(t_item it);
            pending_replies.push_back(predict_map_reply(it));
        endfunction

        function void check_reply(t_result got);
            t_result want;
            if (pending_replies.size() == 0) begin
                $error("reply with no request outstanding: status %0d held %0d",
                       got.status, got.held);
                mismatch_count++;
                return;
            end
            want = pending_replies.pop_front();
            reply_count++;
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatch_count++;
            end
            if (got.art !== want.art) begin
                $error("found_artist: expected %0h, got %0h", want.art, got.art);
                mismatch_count++;
            end
            if (got.alb !== want.alb) begin
                $error("found_album: expected %0h, got %0h", want.alb, got.alb);
                mismatch_count++;
            end
            if (got.tit !== want.tit) begin
                $error("found_title: expected %0h, got %0h", want.tit, got.tit);
                mismatch_count++;
            end
            if (got.held !== want.held) begin
                $error("entries_held: expected %0d, got %0d", want.held, got.held);
                mismatch_count++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [LIM_W-1:0]      i_cfg_data      = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata  = '0;
    logic [REQ_W-1:0]      i_s_axis_tuser  = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [STAT_W-1:0]     o_m_axis_tuser;

    probe_map_scoreboard ledger;
    t_item               outgoing [$];
    logic [KEY_W-1:0]    known_keys [$];
    int                  burst_left  = 0;
    int                  quiet_count = 0;
    bit                  hold_off_req = 1'b0;

    hash_key_linear_probe_map_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // transfer monitor and watchdog; values seen here are the pre-edge ones
    always @(posedge i_clk) begin
        t_item   req;
        t_result rsp;
        bit      moved;
        moved = 1'b0;
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            req.req = t_req'(i_s_axis_tuser);
            req.key = i_s_axis_tdata[31:0];
            req.art = i_s_axis_tdata[48:32];
            req.alb = i_s_axis_tdata[65:49];
            req.tit = i_s_axis_tdata[82:66];
            ledger.note_request(req);
            moved = 1'b1;
        end
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            rsp.status = t_status'(o_m_axis_tuser);
            rsp.art    = o_m_axis_tdata[16:0];
            rsp.alb    = o_m_axis_tdata[33:17];
            rsp.tit    = o_m_axis_tdata[50:34];
            rsp.held   = o_m_axis_tdata[63:51];
            ledger.check_reply(rsp);
            moved = 1'b1;
        end
        if (i_cfg_valid && o_cfg_ready) moved = 1'b1;
        quiet_count = moved ? 0 : quiet_count + 1;
        if (quiet_count >= QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // receiver pacing, with one long hold-off on request
    initial begin
        int mode;
        int span;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 64);
            repeat (span) begin
                case (mode)
                    0:       i_m_axis_tready <= 1'b1;
                    1:       i_m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: i_m_axis_tready <= ($urandom_range(0, 9) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    task automatic push_item(input t_req rq, input logic [KEY_W-1:0] k,
                             input logic [OFS_W-1:0] a, input logic [OFS_W-1:0] b,
                             input logic [OFS_W-1:0] t);
        t_item it;
        it.req = rq;
        it.key = k;
        it.art = a;
        it.alb = b;
        it.tit = t;
        outgoing.push_back(it);
    endtask

    task automatic send_all();
        t_item it;
        int    gap;
        logic [IN_DATA_W-1:0] d;
        while (outgoing.size() != 0) begin
            it = outgoing.pop_front();
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0) begin
                    i_s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
            d = '0;
            d[31:0]  = it.key;
            d[48:32] = it.art;
            d[65:49] = it.alb;
            d[82:66] = it.tit;
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tdata  <= d;
            i_s_axis_tuser  <= it.req;
            do @(posedge i_clk); while (!o_s_axis_tready);
        end
        i_s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_settled(input int tail);
        while (ledger.pending_replies.size() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIM_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        ledger.set_limit(v);
        @(posedge i_clk);
    endtask

    // mostly inserts and lookups of keys already placed; some share home slots
    task automatic queue_traffic(input int count);
        int    roll;
        t_item it;
        repeat (count) begin
            roll   = $urandom_range(0, 99);
            it.art = OFS_W'($urandom_range(0, 17'h1FFFF));
            it.alb = OFS_W'($urandom_range(0, 17'h1FFFF));
            it.tit = OFS_W'($urandom_range(0, 17'h1FFFF));
            it.key = $urandom();
            if (roll == 0) begin
                it.req = REQ_CLEAR;
            end else if (roll < 3) begin
                it.req = REQ_IGNORE;
            end else if (roll < 50) begin
                it.req = REQ_INSERT;
                roll = $urandom_range(0, 99);
                if (roll < 15)
                    it.key[12:0] = CLUSTER_BASE + 13'($urandom_range(0, 15));
                else if (roll < 25 && known_keys.size() != 0)
                    it.key = known_keys[$urandom_range(0, known_keys.size() - 1)];
                known_keys.push_back(it.key);
                if (known_keys.size() > 512) void'(known_keys.pop_front());
            end else begin
                it.req = REQ_LOOKUP;
                if ($urandom_range(0, 4) != 0 && known_keys.size() != 0)
                    it.key = known_keys[$urandom_range(0, known_keys.size() - 1)];
            end
            outgoing.push_back(it);
        end
    endtask

    initial begin
        logic [LIM_W-1:0] limits [6];
        ledger = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty map, extremes, collisions, wrap, duplicates, ignored, clear
        push_item(REQ_LOOKUP, 32'h0000_0000, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
        push_item(REQ_INSERT, 32'h0000_0000, 17'h00000, 17'h00000, 17'h00000);
        push_item(REQ_INSERT, 32'hFFFF_FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
        push_item(REQ_LOOKUP, 32'hFFFF_FFFF, 17'h00000, 17'h00000, 17'h00000);
        push_item(REQ_LOOKUP, 32'h0000_0000, 17'h00000, 17'h00000, 17'h00000);
        push_item(REQ_INSERT, 32'h0000_2000, 17'h00001, 17'h00002, 17'h00003);
        push_item(REQ_INSERT, 32'h0000_0000, 17'h0AAAA, 17'h15555, 17'h0F0F0);
        push_item(REQ_LOOKUP, 32'h0000_0000, 17'h00000, 17'h00000, 17'h00000);
        push_item(REQ_LOOKUP, 32'h0000_2000, 17'h00000, 17'h00000, 17'h00000);
        push_item(REQ_LOOKUP, 32'h0000_4000, 17'h00000, 17'h00000, 17'h00000);
        push_item(REQ_INSERT, 32'h0000_1FFF, 17'h10000, 17'h08000, 17'h04000);
        push_item(REQ_LOOKUP, 32'h0000_1FFF, 17'h00000, 17'h00000, 17'h00000);
        push_item(REQ_IGNORE, 32'hA5A5_5A5A, 17'h1FFFF, 17'h00000, 17'h1FFFF);
        push_item(REQ_CLEAR,  32'h0000_0000, 17'h00000, 17'h00000, 17'h00000);
        push_item(REQ_LOOKUP, 32'hFFFF_FFFF, 17'h00000, 17'h00000, 17'h00000);
        push_item(REQ_INSERT, 32'h1234_5678, 17'h0AAAA, 17'h15555, 17'h0AAAA);
        push_item(REQ_LOOKUP, 32'h1234_5678, 17'h00000, 17'h00000, 17'h00000);
        push_item(REQ_LOOKUP, 32'h1234_5679, 17'h00000, 17'h00000, 17'h00000);
        send_all();
        wait_settled(4);

        // smallest limit: a map already holding one entry refuses inserts
        write_limit(13'd1);
        push_item(REQ_INSERT, 32'h8000_0001, 17'h00001, 17'h00001, 17'h00001);
        push_item(REQ_LOOKUP, 32'h1234_5678, 17'h00000, 17'h00000, 17'h00000);
        push_item(REQ_CLEAR,  32'h0000_0000, 17'h00000, 17'h00000, 17'h00000);
        push_item(REQ_INSERT, 32'h8000_0001, 17'h1FFFF, 17'h00000, 17'h00001);
        push_item(REQ_INSERT, 32'h8000_0002, 17'h00002, 17'h00002, 17'h00002);
        send_all();
        wait_settled(4);

        limits[0] = 13'd4096;
        limits[1] = 13'($urandom_range(2, 40));
        limits[2] = 13'd1;
        limits[3] = 13'($urandom_range(100, 600));
        limits[4] = 13'($urandom_range(1, 4096));
        limits[5] = 13'd4096;
        for (int p = 0; p < 6; p++) begin
            write_limit(limits[p]);
            queue_traffic(205);
            if (p == 3) hold_off_req = 1'b1;
            send_all();
            wait_settled(4);
        end

        wait_settled(40);
        $display("checked %0d replies: %0d stored, %0d refused as full, %0d hits, %0d misses",
                 ledger.reply_count, ledger.stored_count, ledger.refused_count,
                 ledger.hit_count, ledger.miss_count);
        $display("map cleared %0d times, %0d unknown requests, entry limits 1 to 4096",
                 ledger.clear_count, ledger.ignored_count);
        if (ledger.mismatch_count == 0 && ledger.pending_replies.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
